// File: design/adsr_envelope_generator_macros.svh
// assertion macros for the envelope generator
`ifndef ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`define ADSR_ENVELOPE_GENERATOR_MACROS_SVH
`ifndef SYNTHESIS
`define ADSR_ASSERT_SAME(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("envelope assertion failed");
`define ADSR_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("envelope assertion failed");
`else
`define ADSR_ASSERT_SAME(lbl, ck, rn, ante, cons)
`define ADSR_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

// File: design/adsr_pkg.sv
package adsr_pkg;

	// register indexes on the configuration port
	localparam logic [1:0] REG_ATTACK_LEN    = 2'd0;
	localparam logic [1:0] REG_DECAY_LEN     = 2'd1;
	localparam logic [1:0] REG_SUSTAIN_LEVEL = 2'd2;
	localparam logic [1:0] REG_RELEASE_LEN   = 2'd3;

	// status of the serial divider
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: design/adsr_div.sv
module adsr_div import adsr_pkg::*; #(
	parameter int LEN_BITS   = 20,
	parameter int LEVEL_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [LEN_BITS+LEVEL_BITS-1:0] dividend,
	input  logic [LEN_BITS-1:0]            divisor,
	output logic [LEVEL_BITS-1:0]          quotient,
	output div_stat_t                      stat
);

	localparam int CNT_W = $clog2(LEVEL_BITS + 1);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [LEN_BITS-1:0]   rem_q;
	logic [LEN_BITS-1:0]   div_q;
	logic [LEVEL_BITS-1:0] quo_q;

	logic [LEN_BITS:0] trial;
	logic [LEN_BITS:0] diff;
	logic              ge;

	// restoring step: the quotient is known to fit, so the top bits start
	// as a partial remainder below the divisor
	assign trial = {rem_q, quo_q[LEVEL_BITS-1]};
	assign diff  = trial - {1'b0, div_q};
	assign ge    = trial >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(LEVEL_BITS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[LEN_BITS+LEVEL_BITS-1:LEVEL_BITS];
			quo_q <= dividend[LEVEL_BITS-1:0];
			div_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
			quo_q <= {quo_q[LEVEL_BITS-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

// File: design/adsr_envelope_generator.sv
// linear adsr envelope, one level word per sample word
// timed phases go through the accept cycle, one or more settle steps, a multiply,
// the divider start and wait, and a finish step; sustain and done skip the
// multiply and the divider and go from settle straight to finish; the next
// word is taken once the result is held
// reset puts the envelope at the first attack sample with the default lengths
module adsr_envelope_generator import adsr_pkg::*; #(
	parameter int LEN_BITS   = 20,
	parameter int LEVEL_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [3:0]            paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  release_req,
	input  logic                  retrigger,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LEVEL_BITS-1:0] level,
	output logic [2:0]            phase,
	output logic                  done_res
);

	`include "adsr_envelope_generator_macros.svh"

	localparam int PROD_W = LEN_BITS + LEVEL_BITS;
	localparam logic [LEVEL_BITS-1:0] FULL = '1;

	typedef enum logic [2:0] {
		PH_ATTACK  = 3'd0,
		PH_DECAY   = 3'd1,
		PH_SUSTAIN = 3'd2,
		PH_RELEASE = 3'd3,
		PH_DONE    = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SETTLE,
		S_MUL,
		S_DIVGO,
		S_DIVW,
		S_FIN
	} state_t;

	state_t                state_q;
	phase_t                phase_q;
	logic [LEN_BITS-1:0]   pos_q;
	logic [LEVEL_BITS-1:0] res_q;
	logic                  out_valid_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [2:0]            phase_out_q;
	logic                  done_q;

	logic [LEN_BITS-1:0]   attack_len_q;
	logic [LEN_BITS-1:0]   decay_len_q;
	logic [LEVEL_BITS-1:0] sustain_q;
	logic [LEN_BITS-1:0]   release_len_q;

	logic [PROD_W-1:0]     prod_q;
	logic [LEN_BITS-1:0]   divisor_q;

	logic [LEN_BITS-1:0]   len_sel;
	logic [LEVEL_BITS-1:0] k_sel;
	logic                  timed;
	logic                  cfg_wr;
	logic                  accept;
	logic                  out_free;
	logic                  div_start;
	logic [LEVEL_BITS-1:0] quotient;
	div_stat_t             div_stat;

	// configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_len_q  <= LEN_BITS'(480);
			decay_len_q   <= LEN_BITS'(4800);
			sustain_q     <= LEVEL_BITS'(49152);
			release_len_q <= LEN_BITS'(9600);
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ATTACK_LEN:    attack_len_q  <= pwdata[LEN_BITS-1:0];
				REG_DECAY_LEN:     decay_len_q   <= pwdata[LEN_BITS-1:0];
				REG_SUSTAIN_LEVEL: sustain_q     <= pwdata[LEVEL_BITS-1:0];
				REG_RELEASE_LEN:   release_len_q <= pwdata[LEN_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ATTACK_LEN:    prdata = 32'(attack_len_q);
			REG_DECAY_LEN:     prdata = 32'(decay_len_q);
			REG_SUSTAIN_LEVEL: prdata = 32'(sustain_q);
			REG_RELEASE_LEN:   prdata = 32'(release_len_q);
			default:           prdata = '0;
		endcase
	end

	// per-phase length and slope scale
	always_comb begin
		case (phase_q)
			PH_ATTACK: begin
				len_sel = attack_len_q;
				k_sel   = FULL;
				timed   = 1'b1;
			end
			PH_DECAY: begin
				len_sel = decay_len_q;
				k_sel   = FULL - sustain_q;
				timed   = 1'b1;
			end
			PH_RELEASE: begin
				len_sel = release_len_q;
				k_sel   = sustain_q;
				timed   = 1'b1;
			end
			default: begin
				len_sel = release_len_q;
				k_sel   = sustain_q;
				timed   = 1'b0;
			end
		endcase
	end

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign div_start = (state_q == S_DIVGO);

	always_ff @(posedge clk) begin
		if (state_q == S_MUL) begin
			prod_q    <= PROD_W'(k_sel) * PROD_W'(pos_q);
			divisor_q <= len_sel;
		end
	end

	adsr_div #(
		.LEN_BITS   (LEN_BITS),
		.LEVEL_BITS (LEVEL_BITS)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (divisor_q),
		.quotient (quotient),
		.stat     (div_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			phase_q     <= PH_ATTACK;
			pos_q       <= '0;
			res_q       <= '0;
			out_valid_q <= 1'b0;
			level_q     <= '0;
			phase_out_q <= '0;
			done_q      <= 1'b0;
		end else begin
			if (state_q == S_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						// release request first, retrigger only when no release is requested
						if (release_req) begin
							phase_q <= PH_RELEASE;
							pos_q   <= '0;
						end else if (retrigger) begin
							phase_q <= PH_ATTACK;
							pos_q   <= '0;
						end
						state_q <= S_SETTLE;
					end
				end
				S_SETTLE: begin
					// one phase step per cycle past ended or empty phases
					if (timed && !(pos_q < len_sel)) begin
						pos_q <= '0;
						case (phase_q)
							PH_ATTACK: phase_q <= PH_DECAY;
							PH_DECAY:  phase_q <= PH_SUSTAIN;
							default:   phase_q <= PH_DONE;
						endcase
					end else if (timed) begin
						state_q <= S_MUL;
					end else begin
						res_q   <= (phase_q == PH_SUSTAIN) ? sustain_q : '0;
						state_q <= S_FIN;
					end
				end
				S_MUL: begin
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= S_DIVW;
				end
				S_DIVW: begin
					if (div_stat.done) begin
						case (phase_q)
							PH_ATTACK: res_q <= quotient;
							PH_DECAY:  res_q <= FULL - quotient;
							default:   res_q <= sustain_q - quotient;
						endcase
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						level_q     <= res_q;
						phase_out_q <= phase_q;
						done_q      <= (phase_q == PH_DONE);
						pos_q       <= timed ? pos_q + LEN_BITS'(1) : '0;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign level     = level_q;
	assign phase     = phase_out_q;
	assign done_res  = done_q;

	`ADSR_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, accept, in_stall)
	`ADSR_ASSERT_SAME(a_done_matches_phase, clk, arst_n, out_valid, done_res == (phase == 3'(PH_DONE)))
	`ADSR_ASSERT_SAME(a_div_only_in_wait, clk, arst_n, div_stat.busy, state_q == S_DIVW)
	`ADSR_ASSERT_NEXT(a_held_result, clk, arst_n, out_valid && out_stall, out_valid && $stable(level))

endmodule
